[rtl/core/uhb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhb_pkg
// Constants shared by the UDP/IPv4 frame header builder: header layout,
// fixed header field values, configuration register indexes and resets.
// ----------------------------------------------------------------------------
package uhb_pkg;

    localparam int HDR_BYTES   = 42;
    localparam int HDR_BITS    = HDR_BYTES * 8;
    localparam int FRAME_LIMIT = 4096;

    localparam int REQ_WIDTH   = 80;
    localparam int CFG_WIDTH   = 48;
    localparam int CNT_WIDTH   = 6;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [7:0]  IP_TOS        = 8'h00;
    localparam logic [7:0]  IP_TTL        = 8'd100;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [15:0] IP_HDR_LEN    = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN   = 16'd8;

    localparam logic [1:0] CFG_SRC_MAC  = 2'd0;
    localparam logic [1:0] CFG_PEER_MAC = 2'd1;
    localparam logic [1:0] CFG_SRC_IP   = 2'd2;

    localparam logic [47:0] SRC_MAC_RESET  = 48'h525400123456;
    localparam logic [47:0] PEER_MAC_RESET = 48'h52550a000202;
    localparam logic [31:0] SRC_IP_RESET   = 32'h0a00020f;

endpackage

[rtl/core/udp_ipv4_frame_header_builder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_ipv4_frame_header_builder_core
// Builds the 42-byte Ethernet/IPv4/UDP header for one send request.
//
// A request word enters on s_axis and leaves as 42 header bytes on m_axis in
// wire order, tlast on the final byte. A request whose frame would exceed the
// frame limit gives a single word with tuser set, tlast set and data zero.
// The MAC and IP registers are written through cfg_we/cfg_index/cfg_wdata.
//
// Three pipeline stages (length check, checksum sum, checksum fold) feed a
// byte serializer, whose register drives m_axis. The serializer sends one
// byte per cycle while m_axis_tready is high; the next request is loaded as
// the last byte is taken, so bytes of back-to-back requests follow without
// gaps. Reset empties the pipeline and serializer and restores the default
// addresses. When the receiver stalls, the current byte holds and the
// pipeline fills and then drops s_axis_tready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module udp_ipv4_frame_header_builder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [uhb_pkg::CFG_WIDTH-1:0] cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // dest_ip[31:0], source_port[47:32], dest_port[63:48], payload_length[79:64]
    input  logic [uhb_pkg::REQ_WIDTH-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // header_byte[7:0]
    output logic [7:0]                    m_axis_tdata,
    output logic                          m_axis_tlast,
    // too_long[0]
    output logic                          m_axis_tuser
);
    import uhb_pkg::*;

    logic [47:0] src_mac_reg;
    logic [47:0] peer_mac_reg;
    logic [31:0] src_ip_reg;

    logic        s1_valid_reg;
    logic        s1_long_reg;
    logic [31:0] s1_dip_reg;
    logic [15:0] s1_sport_reg;
    logic [15:0] s1_dport_reg;
    logic [15:0] s1_iplen_reg;
    logic [15:0] s1_udplen_reg;

    logic        s2_valid_reg;
    logic        s2_long_reg;
    logic [31:0] s2_dip_reg;
    logic [15:0] s2_sport_reg;
    logic [15:0] s2_dport_reg;
    logic [15:0] s2_iplen_reg;
    logic [15:0] s2_udplen_reg;
    logic [18:0] s2_sum_reg;

    logic        s3_valid_reg;
    logic        s3_long_reg;
    logic [31:0] s3_dip_reg;
    logic [15:0] s3_sport_reg;
    logic [15:0] s3_dport_reg;
    logic [15:0] s3_iplen_reg;
    logic [15:0] s3_udplen_reg;
    logic [15:0] s3_csum_reg;

    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic                  out_user_reg;
    logic [HDR_BITS-1:0]   shift_reg;
    logic [CNT_WIDTH-1:0]  count_reg;

    logic                  out_valid_next;
    logic                  out_last_next;
    logic                  out_user_next;
    logic [HDR_BITS-1:0]   shift_next;
    logic [CNT_WIDTH-1:0]  count_next;

    logic        ser_load;
    logic        s1_ready;
    logic        s2_ready;
    logic        s3_ready;
    logic        in_fire;
    logic        out_fire;

    logic [31:0] in_dip;
    logic [15:0] in_sport;
    logic [15:0] in_dport;
    logic [15:0] in_plen;
    logic [16:0] frame_len;
    logic [18:0] sum_next;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [HDR_BITS-1:0] header;

    assign in_dip   = s_axis_tdata[31:0];
    assign in_sport = s_axis_tdata[47:32];
    assign in_dport = s_axis_tdata[63:48];
    assign in_plen  = s_axis_tdata[79:64];

    assign out_fire = out_valid_reg & m_axis_tready;
    assign ser_load = s3_valid_reg & (~out_valid_reg | (m_axis_tready & out_last_reg));
    assign s3_ready = ~s3_valid_reg | ser_load;
    assign s2_ready = ~s2_valid_reg | s3_ready;
    assign s1_ready = ~s1_valid_reg | s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_fire = s_axis_tvalid & s1_ready;

    assign frame_len = {1'b0, in_plen} + 17'(HDR_BYTES);

    assign sum_next = 19'({IP_VER_IHL, IP_TOS}) + {3'b0, s1_iplen_reg}
                    + 19'({IP_TTL, IP_PROTO_UDP})
                    + {3'b0, src_ip_reg[31:16]} + {3'b0, src_ip_reg[15:0]}
                    + {3'b0, s1_dip_reg[31:16]} + {3'b0, s1_dip_reg[15:0]};

    assign fold1 = {1'b0, s2_sum_reg[15:0]} + {14'b0, s2_sum_reg[18:16]};
    assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

    assign header = {peer_mac_reg, src_mac_reg, ETH_TYPE_IPV4, IP_VER_IHL, IP_TOS,
                     s3_iplen_reg, 16'h0000, 16'h0000, IP_TTL, IP_PROTO_UDP,
                     s3_csum_reg, src_ip_reg, s3_dip_reg, s3_sport_reg,
                     s3_dport_reg, s3_udplen_reg, 16'h0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_mac_reg  <= SRC_MAC_RESET;
            peer_mac_reg <= PEER_MAC_RESET;
            src_ip_reg   <= SRC_IP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_MAC:  src_mac_reg  <= cfg_wdata;
                CFG_PEER_MAC: peer_mac_reg <= cfg_wdata;
                CFG_SRC_IP:   src_ip_reg   <= cfg_wdata[31:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_long_reg   <= frame_len > 17'(FRAME_LIMIT);
            s1_dip_reg    <= in_dip;
            s1_sport_reg  <= in_sport;
            s1_dport_reg  <= in_dport;
            s1_iplen_reg  <= in_plen + IP_HDR_LEN + UDP_HDR_LEN;
            s1_udplen_reg <= in_plen + UDP_HDR_LEN;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_long_reg   <= s1_long_reg;
            s2_dip_reg    <= s1_dip_reg;
            s2_sport_reg  <= s1_sport_reg;
            s2_dport_reg  <= s1_dport_reg;
            s2_iplen_reg  <= s1_iplen_reg;
            s2_udplen_reg <= s1_udplen_reg;
            s2_sum_reg    <= sum_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_long_reg   <= s2_long_reg;
            s3_dip_reg    <= s2_dip_reg;
            s3_sport_reg  <= s2_sport_reg;
            s3_dport_reg  <= s2_dport_reg;
            s3_iplen_reg  <= s2_iplen_reg;
            s3_udplen_reg <= s2_udplen_reg;
            s3_csum_reg   <= ~fold2;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        if (ser_load)
        begin
            out_valid_next = 1'b1;
            if (s3_long_reg)
            begin
                out_last_next = 1'b1;
                out_user_next = 1'b1;
                shift_next    = '0;
                count_next    = '0;
            end
            else
            begin
                out_last_next = 1'b0;
                out_user_next = 1'b0;
                shift_next    = header;
                count_next    = CNT_WIDTH'(HDR_BYTES - 1);
            end
        end
        else if (out_fire)
        begin
            if (out_last_reg)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                shift_next    = {shift_reg[HDR_BITS-9:0], 8'h00};
                count_next    = count_reg - 1'b1;
                out_last_next = (count_reg == CNT_WIDTH'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_user_reg <= out_user_next;
        shift_reg    <= shift_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = shift_reg[HDR_BITS-1:HDR_BITS-8];
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
